// ===== sv/jss_pkg.sv =====
// ---------------------------------------------------------------------------
// jss_pkg: shared types and constants of the jump search table
// Field widths, control state encoding and action codes.
// ---------------------------------------------------------------------------
package jss_pkg;

    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int CNT_W   = 12;
    localparam int ROOT_W  = 6;
    localparam int BIT_W   = 3;
    localparam int LIM_W   = 17;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_PROBE,
        ST_SCAN
    } t_state;

endpackage

// ===== sv/jss_ram.sv =====
// ---------------------------------------------------------------------------
// jss_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module jss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/jump_search_sorted_table_core.sv =====
// ---------------------------------------------------------------------------
// jump_search_sorted_table_core: jump search over an ascending table
// Stores signed entries in a RAM and answers searches with a jump step of
// floor(sqrt(count)), followed by a linear scan from the block before the
// first probe that exceeds the sought value, or from entry 0 if none does.
//
// Channel   Direction  Handshake            Payload
// item      in         start && !busy       i_action, i_entry_index, i_entry_value
// result    out        o_done (one cycle)   o_found, o_match_index
// config    in         i_cfg_we             i_cfg_data (entry count)
//
// A write goes straight into the RAM and gives no result; busy stays low.
// A search with a count of zero answers as a miss in the cycle after it is accepted.
// Otherwise a search works out the root bit by bit in ST_ROOT, probes every
// step-th entry in ST_PROBE, then scans in ST_SCAN, one RAM read per cycle.
// Synchronous active-low reset clears the control state; the table is not
// cleared. The receiver cannot stall results.
// ---------------------------------------------------------------------------
module jump_search_sorted_table_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_action,
    input  logic [jss_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic signed [VALUE_WIDTH-1:0]    i_entry_value,
    input  logic                             i_cfg_we,
    input  logic [jss_pkg::COUNT_W-1:0]      i_cfg_data,
    output logic                             o_done,
    output logic                             o_found,
    output logic [jss_pkg::INDEX_W-1:0]      o_match_index
);

    import jss_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_state                   r_state, n_state;
    logic [COUNT_W-1:0]       r_count;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [ROOT_W-1:0]        r_root, n_root;
    logic [BIT_W-1:0]         r_bit, n_bit;
    logic [CNT_W-1:0]         r_iss, n_iss;
    logic                     r_pv, n_pv;
    logic [CNT_W-1:0]         r_pa, n_pa;
    logic [VALUE_WIDTH-1:0]   r_key, n_key;
    logic                     r_done, n_done;
    logic                     r_found, n_found;
    logic [INDEX_W-1:0]       r_idx, n_idx;

    logic                     accept;
    logic                     do_write;
    logic [CNT_W-1:0]         clamp_n;
    logic [ROOT_W-1:0]        cand;
    logic [2*ROOT_W-1:0]      cand_sq;
    logic                     can_issue;
    logic                     rd_en;
    logic [VALUE_WIDTH-1:0]   rdata;
    logic                     exceed;
    logic                     equal;
    logic [CNT_W-1:0]         step;
    logic [CNT_W-1:0]         blk_start;

    assign accept   = start && !busy;
    assign do_write = accept && (i_action == ACT_WRITE)
                      && (LIM_W'(i_entry_index) < LIM_W'(TABLE_DEPTH));
    assign clamp_n  = (LIM_W'(r_count) > LIM_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : CNT_W'(r_count);
    assign cand      = r_root | ROOT_W'(1 << r_bit);
    assign cand_sq   = cand * cand;
    assign step      = CNT_W'(r_root);
    assign can_issue = (r_iss < r_n);
    assign rd_en     = ((r_state == ST_PROBE) || (r_state == ST_SCAN)) && can_issue;
    assign exceed    = $signed(rdata) > $signed(r_key);
    assign equal     = (rdata == r_key);
    assign blk_start = (r_pa >= step) ? (r_pa - step) : '0;

    jss_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_re    (rd_en),
        .i_raddr (AW'(r_iss)),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_SEARCH) && (clamp_n != '0)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_bit == '0) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if ((r_pv && exceed) || (!r_pv && !can_issue)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((r_pv && equal) || (!r_pv && !can_issue)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_n     = r_n;
        n_root  = r_root;
        n_bit   = r_bit;
        n_iss   = r_iss;
        n_pv    = 1'b0;
        n_pa    = r_pa;
        n_key   = r_key;
        n_done  = 1'b0;
        n_found = r_found;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_SEARCH)) begin
                    n_n    = clamp_n;
                    n_key  = i_entry_value;
                    n_root = '0;
                    n_bit  = BIT_W'(ROOT_W - 1);
                    if (clamp_n == '0) begin
                        n_done  = 1'b1;
                        n_found = 1'b0;
                        n_idx   = '0;
                    end
                end
            end
            ST_ROOT: begin
                if (CNT_W'(cand_sq) <= r_n) begin
                    n_root = cand;
                end
                n_bit = r_bit - 1'b1;
                n_iss = '0;
            end
            ST_PROBE: begin
                if (can_issue) begin
                    n_pv  = 1'b1;
                    n_pa  = r_iss;
                    n_iss = r_iss + step;
                end
                if (r_pv && exceed) begin
                    n_pv  = 1'b0;
                    n_iss = blk_start;
                end else if (!r_pv && !can_issue) begin
                    n_iss = '0;
                end
            end
            ST_SCAN: begin
                if (can_issue) begin
                    n_pv  = 1'b1;
                    n_pa  = r_iss;
                    n_iss = r_iss + 1'b1;
                end
                if (r_pv && equal) begin
                    n_pv    = 1'b0;
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_idx   = r_pa[INDEX_W-1:0];
                end else if (!r_pv && !can_issue) begin
                    n_done  = 1'b1;
                    n_found = 1'b0;
                    n_idx   = '0;
                end
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_iss   <= n_iss;
        r_pa    <= n_pa;
        r_key   <= n_key;
        r_found <= n_found;
        r_idx   <= n_idx;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_match_index = r_idx;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_match_index == '0))
        else $error("not-found result with nonzero index");

    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> ((r_state == ST_PROBE) || (r_state == ST_SCAN)))
        else $error("read pending outside probe or scan");

    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (r_pa < r_n))
        else $error("match index beyond entry count");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> ((r_root != '0)
            && (CNT_W'(r_root * r_root) <= r_n)))
        else $error("jump step out of range");

endmodule

// ===== tb/tb_jump_search_sorted_table_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_jump_search_sorted_table_core: self-checking bench for the jump search
// Fills the table with mostly ascending signed words, sets the entry count
// while the core is idle and issues searches. Each search answer is predicted
// from a local copy of the table and count and compared when o_done fires.
// ---------------------------------------------------------------------------
module tb_jump_search_sorted_table_core;

    import jss_pkg::*;

    localparam int     DEPTH      = 1024;
    localparam int     VW         = 32;
    localparam int     SETTLE     = 3;
    localparam int     TAIL_OPS   = 150;
    localparam int     QUIET_MAX  = 6000;
    localparam int     MAX_REPORT = 10;
    localparam longint VMIN       = -64'sd2147483648;
    localparam longint VMAX       = 64'sd2147483647;

    typedef struct {
        bit                  is_cfg;
        logic [COUNT_W-1:0]  count;
        logic                action;
        logic [INDEX_W-1:0]  idx;
        logic signed [VW-1:0] val;
    } t_op;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] idx;
    } t_answer;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    logic                  i_action      = ACT_WRITE;
    logic [INDEX_W-1:0]    i_entry_index = '0;
    logic signed [VW-1:0]  i_entry_value = '0;
    logic                  i_cfg_we      = 1'b0;
    logic [COUNT_W-1:0]    i_cfg_data    = '0;
    logic                  o_done;
    logic                  o_found;
    logic [INDEX_W-1:0]    o_match_index;

    t_op                   pending_ops[$];
    t_answer               answers_due[$];
    logic signed [VW-1:0]  shadow_tbl [DEPTH];
    logic signed [VW-1:0]  plan_tbl   [DEPTH];
    logic [COUNT_W-1:0]    model_count = '0;
    int                    plan_fill    = 0;
    int                    planned_items = 0;
    int                    mismatches   = 0;
    int                    quiet_cycles = 0;
    int                    quiet_run    = 0;
    int                    gap_left     = 0;
    bit                    took         = 1'b0;
    bit                    live         = 1'b0;

    jump_search_sorted_table_core #(
        .TABLE_DEPTH (DEPTH),
        .VALUE_WIDTH (VW)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_match_index (o_match_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_answer jump_lookup(input logic signed [VW-1:0] key);
        t_answer r;
        int      n;
        int      stride;
        int      scan_at;
        int      i;
        bit      passed;
        r = '0;
        n = (model_count > DEPTH) ? DEPTH : int'(model_count);
        if (n != 0) begin
            stride = 0;
            while ((stride + 1) * (stride + 1) <= n) stride++;
            scan_at = 0;
            passed  = 1'b0;
            for (i = 0; i < n && !passed; i += stride) begin
                if (shadow_tbl[i] > key) begin
                    passed  = 1'b1;
                    scan_at = (i >= stride) ? i - stride : 0;
                end
            end
            for (i = scan_at; i < n && !r.found; i++) begin
                if (shadow_tbl[i] == key) begin
                    r.found = 1'b1;
                    r.idx   = INDEX_W'(i);
                end
            end
        end
        return r;
    endfunction

    task automatic push_cfg(input int n);
        t_op op;
        op        = '{default: '0};
        op.is_cfg = 1'b1;
        op.count  = COUNT_W'(n);
        pending_ops.push_back(op);
    endtask

    task automatic push_write(input int idx, input logic signed [VW-1:0] val);
        t_op op;
        op        = '{default: '0};
        op.action = ACT_WRITE;
        op.idx    = INDEX_W'(idx);
        op.val    = val;
        plan_tbl[idx] = val;
        pending_ops.push_back(op);
        planned_items++;
    endtask

    task automatic push_search(input logic signed [VW-1:0] val);
        t_op op;
        op        = '{default: '0};
        op.action = ACT_SEARCH;
        op.idx    = INDEX_W'($urandom);
        op.val    = val;
        pending_ops.push_back(op);
        planned_items++;
    endtask

    // ascending entries 0..n-1, with runs of duplicates for the narrow spacing
    task automatic fill_sorted(input int n);
        longint cur;
        longint hop;
        int     i;
        cur = ($urandom_range(0, 3) == 0) ? VMIN : longint'(int'($urandom));
        case ($urandom_range(0, 3))
            0: hop = 3;
            1: hop = 1000;
            2: hop = 64'sd16777216;
            default: begin
                hop = 64'sd4294967296 / (n + 1);
                cur = VMIN;
            end
        endcase
        for (i = 0; i < n; i++) begin
            if (i == n - 1 && $urandom_range(0, 3) == 0) cur = VMAX;
            push_write(i, VW'(cur));
            cur += longint'($urandom_range(0, 32'(hop)));
            if (cur > VMAX) cur = VMAX;
        end
        if (n > plan_fill) plan_fill = n;
    endtask

    function automatic logic signed [VW-1:0] pick_key(input int n);
        int                   sel;
        logic signed [VW-1:0] v;
        sel = $urandom_range(0, 9);
        if (n == 0) sel = 9;
        case (sel)
            0, 1, 2, 3, 4: v = plan_tbl[$urandom_range(0, n - 1)];
            5:       v = plan_tbl[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
            6:       v = plan_tbl[0] - 1;
            7:       v = plan_tbl[n - 1] + 1;
            8:       v = $urandom_range(0, 1) ? VW'(VMIN) : VW'(VMAX);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic run_phase(input int n, input int k);
        int j;
        if (n > plan_fill || (n <= 200 && $urandom_range(0, 2) != 0)) fill_sorted(n);
        push_cfg(n);
        for (j = 0; j < k; j++) begin
            if ($urandom_range(0, 9) == 0)
                push_write($urandom_range(0, DEPTH - 1), $urandom);
            else
                push_search(pick_key(n));
        end
    endtask

    task automatic build_stimulus();
        int target;
        int sel;
        int n;
        bit big_done;
        // zero count: every search misses
        push_cfg(0);
        push_search(VW'(VMIN));
        push_search(VW'(VMAX));
        push_search(0);
        // single entry
        push_write(0, VW'(VMIN));
        push_write(DEPTH - 1, VW'(VMAX));
        push_cfg(1);
        push_search(VW'(VMIN));
        push_search(VW'(VMAX));
        // nine entries, step of three, with duplicates and both extremes
        push_write(1, -50);
        push_write(2, -50);
        push_write(3, 0);
        push_write(4, 7);
        push_write(5, 7);
        push_write(6, 100);
        push_write(7, 1000);
        push_write(8, VW'(VMAX));
        push_cfg(9);
        push_search(VW'(VMIN));
        push_search(-100);
        push_search(-50);
        push_search(7);
        push_search(VW'(VMAX));
        push_search(101);
        // break the order: no probe exceeds, then the first probe exceeds
        push_write(2, 5000);
        push_search(5000);
        push_write(0, VW'(VMAX));
        push_search(7);
        push_search(VW'(VMIN));
        plan_fill = 9;

        big_done = 1'b0;
        target   = planned_items + 1300;
        while (planned_items < target) begin
            if (!big_done && planned_items > target - 1200) begin
                fill_sorted(DEPTH);
                push_cfg(DEPTH);
                run_phase(DEPTH, 20);
                big_done = 1'b1;
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0)       n = 0;
                else if (sel < 14)  n = $urandom_range(1, 40);
                else if (sel < 18)  n = $urandom_range(41, 200);
                else if (big_done)  n = $urandom_range(201, DEPTH);
                else                n = $urandom_range(1, 16);
                run_phase(n, $urandom_range(4, 24));
            end
        end
    endtask

    always @(negedge i_clk) begin : drive_proc
        logic nxt_start;
        logic nxt_we;
        nxt_start = 1'b0;
        nxt_we    = 1'b0;
        if (live) begin
            if (start && !took) begin
                nxt_start = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_ops.size() != 0) begin
                if (pending_ops[0].is_cfg) begin
                    if (answers_due.size() == 0 && !busy) quiet_run++;
                    else quiet_run = 0;
                    if (quiet_run > SETTLE) begin
                        nxt_we     = 1'b1;
                        i_cfg_data <= pending_ops[0].count;
                        void'(pending_ops.pop_front());
                        quiet_run  = 0;
                    end
                end else if (took && pending_ops.size() > TAIL_OPS &&
                             $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 17) - 1;
                end else begin
                    nxt_start     = 1'b1;
                    i_action      <= pending_ops[0].action;
                    i_entry_index <= pending_ops[0].idx;
                    i_entry_value <= pending_ops[0].val;
                end
            end
            took = 1'b0;
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    always @(posedge i_clk) begin : watch_proc
        t_answer due;
        if (i_rst_n) begin
            if (i_cfg_we) model_count = i_cfg_data;
            if (o_done) begin
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("result with nothing due: found=%0d index=%0d",
                                 o_found, o_match_index);
                end else begin
                    due = answers_due.pop_front();
                    if (o_found !== due.found || o_match_index !== due.idx) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT)
                            $display("mismatch: exp found=%0d index=%0d, got found=%0d index=%0d",
                                     due.found, due.idx, o_found, o_match_index);
                    end
                end
            end
            if (start && !busy) begin
                if (i_action == ACT_WRITE)
                    shadow_tbl[i_entry_index] = i_entry_value;
                else
                    answers_due.push_back(jump_lookup(i_entry_value));
                void'(pending_ops.pop_front());
                took = 1'b1;
            end
            if (i_cfg_we || o_done || (start && !busy)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("tb_jump_search_sorted_table_core: done, errors");
                $finish;
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        live = 1'b1;
        while (pending_ops.size() != 0 || answers_due.size() != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb_jump_search_sorted_table_core: done, clean");
        else
            $display("tb_jump_search_sorted_table_core: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/jss_pkg.sv
sv/jss_ram.sv
sv/jump_search_sorted_table_core.sv
tb/tb_jump_search_sorted_table_core.sv
